### src/qach_pkg.sv
// Shared constants and field layout for the quad anode centroid hit classifier.
`default_nettype none
package qach_pkg;

    localparam int TUBES_PER_UNIT = 6;
    localparam int ADC_BITS       = 12;

    localparam int CFG_BITS    = 12;
    localparam int UNIT_BITS   = 4;
    localparam int TUBE_BITS   = $clog2(TUBES_PER_UNIT);
    localparam int SUM2_BITS   = ADC_BITS + 1;
    localparam int ENERGY_BITS = ADC_BITS + 2;
    localparam int Q_BITS      = 15;
    localparam int POS_BITS    = Q_BITS + 1;
    localparam int CLASS_BITS  = 3;
    localparam int TALLY_BITS  = 2;
    localparam int CNT_BITS    = $clog2(Q_BITS);

    localparam int IN_TDATA_W  = ((4 * ADC_BITS + 7) / 8) * 8;
    localparam int IN_TUSER_W  = UNIT_BITS + TUBE_BITS;
    localparam int OUT_FIELD_W = 1 + ENERGY_BITS + 2 * POS_BITS + 2 + CLASS_BITS;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W = UNIT_BITS + TUBE_BITS;

    // output tdata bit offsets
    localparam int OFS_HIT    = 0;
    localparam int OFS_ENERGY = OFS_HIT + 1;
    localparam int OFS_POSX   = OFS_ENERGY + ENERGY_BITS;
    localparam int OFS_POSY   = OFS_POSX + POS_BITS;
    localparam int OFS_OVF    = OFS_POSY + POS_BITS;
    localparam int OFS_LACK   = OFS_OVF + 1;
    localparam int OFS_CLASS  = OFS_LACK + 1;

    localparam logic [0:0] REG_HIT_THRESHOLD  = 1'b0;
    localparam logic [0:0] REG_OVERFLOW_LIMIT = 1'b1;

    localparam logic [CFG_BITS-1:0] RESET_THRESHOLD = CFG_BITS'(33);
    localparam logic [CFG_BITS-1:0] RESET_OVERFLOW  = CFG_BITS'(4000);

    localparam logic [CLASS_BITS-1:0] CLASS_ERROR = CLASS_BITS'(4);

endpackage
`default_nettype wire

### src/quad_anode_centroid_hit_classifier_top.sv
// Top level: per-tube energy, Anger centroids and per-event hit classification.
`default_nettype none
// Each accepted transfer carries the four anode samples of one tube. Samples
// above overflow_limit flag overflow; the others above hit_threshold pass. A
// tube with all four passing is a hit, and its energy is the sum of the four;
// for a hit, a single shared radix-2 restoring divider computes x, then y,
// one quotient bit per cycle, and the result is then loaded into the output
// register; a non-hit goes to the output load directly. A new item is not
// accepted before the last one is loaded, as input is accepted only while
// the block is idle; a finished result sits in the output register until
// taken, so the next item can be accepted meanwhile, but a new result waits
// for that register to free up. The transfer with tlast set closes the
// event; its result carries the event class and has tlast set.
module quad_anode_centroid_hit_classifier_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [0:0]                       cfg_addr,
    input  wire logic [qach_pkg::CFG_BITS-1:0]    cfg_wdata,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // sample_a, sample_b, sample_c, sample_d
    input  wire logic [qach_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // unit_index, tube_index
    input  wire logic [qach_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    input  wire logic                             s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // hit_valid, energy_sum, pos_x, pos_y, tube_overflow, tube_data_lack,
    // event_class, zero pad
    output logic [qach_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // unit_echo, tube_echo
    output logic [qach_pkg::OUT_TUSER_W-1:0]      m_axis_tuser,
    output logic                                  m_axis_tlast
);
    import qach_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIVX  = 4'b0010,
        ST_DIVY  = 4'b0100,
        ST_WRITE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_BITS-1:0]    thr_reg, ovl_reg;
    logic [TALLY_BITS-1:0]  tally_reg, tally_next;
    logic                   ovf_seen_reg, ovf_seen_next;
    logic                   lack_seen_reg, lack_seen_next;

    logic                   hit_reg, hit_next;
    logic                   ovf_reg, ovf_next;
    logic                   lack_reg, lack_next;
    logic [ENERGY_BITS-1:0] energy_reg, energy_next;
    logic [SUM2_BITS-1:0]   magy_reg, magy_next;
    logic                   negx_reg, negx_next;
    logic                   negy_reg, negy_next;
    logic [UNIT_BITS-1:0]   unit_reg, unit_next;
    logic [TUBE_BITS-1:0]   tube_reg, tube_next;
    logic                   done_reg, done_next;
    logic [CLASS_BITS-1:0]  class_reg, class_next;

    logic [ENERGY_BITS-1:0] rem_reg, rem_next;
    logic [Q_BITS-1:0]      quot_reg, quot_next;
    logic [Q_BITS-1:0]      qx_reg, qx_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;

    logic                   mvalid_reg, mvalid_next;
    logic [OUT_TDATA_W-1:0] mdata_reg, mdata_next;
    logic [OUT_TUSER_W-1:0] muser_reg, muser_next;
    logic                   mlast_reg, mlast_next;

    logic [ADC_BITS-1:0]    smp [4];
    logic [3:0]             smp_ovf, smp_pass;
    logic                   in_hit, in_ovf, in_lack, in_fire, out_load;
    logic [SUM2_BITS-1:0]   sab, scd, sad, sbc;
    logic [ENERGY_BITS-1:0] in_energy;
    logic [TALLY_BITS-1:0]  tally_inc;
    logic                   evt_ovf, evt_lack;

    logic [ENERGY_BITS:0]   rem_sh;
    logic                   div_ge;
    logic [ENERGY_BITS:0]   rem_sub;
    logic [POS_BITS-1:0]    posx, posy;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = mdata_reg;
    assign m_axis_tuser  = muser_reg;
    assign m_axis_tlast  = mlast_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            smp[i]      = s_axis_tdata[i*ADC_BITS +: ADC_BITS];
            smp_ovf[i]  = smp[i] > ovl_reg;
            smp_pass[i] = !smp_ovf[i] && (smp[i] > thr_reg);
        end
        in_ovf  = |smp_ovf;
        in_hit  = &smp_pass;
        in_lack = (|smp_pass) && !in_hit;
        sab = SUM2_BITS'(smp[0]) + SUM2_BITS'(smp[1]);
        scd = SUM2_BITS'(smp[2]) + SUM2_BITS'(smp[3]);
        sad = SUM2_BITS'(smp[0]) + SUM2_BITS'(smp[3]);
        sbc = SUM2_BITS'(smp[1]) + SUM2_BITS'(smp[2]);
        in_energy = ENERGY_BITS'(sab) + ENERGY_BITS'(scd);
        tally_inc = (in_hit && tally_reg != '1) ? tally_reg + 1'b1 : tally_reg;
        evt_ovf   = ovf_seen_reg || in_ovf;
        evt_lack  = lack_seen_reg || in_lack;
    end

    // shared divider step
    always_comb
    begin
        rem_sh  = {rem_reg, 1'b0};
        div_ge  = rem_sh >= {1'b0, energy_reg};
        rem_sub = rem_sh - {1'b0, energy_reg};
    end

    always_comb
    begin
        posx = negx_reg ? -{1'b0, qx_reg} : {1'b0, qx_reg};
        posy = negy_reg ? -{1'b0, quot_reg} : {1'b0, quot_reg};
        if (!hit_reg)
        begin
            posx = '0;
            posy = '0;
        end
    end

    assign out_load = (state_reg == ST_WRITE) && (!mvalid_reg || m_axis_tready);

    always_comb
    begin
        state_next     = state_reg;
        tally_next     = tally_reg;
        ovf_seen_next  = ovf_seen_reg;
        lack_seen_next = lack_seen_reg;
        hit_next       = hit_reg;
        ovf_next       = ovf_reg;
        lack_next      = lack_reg;
        energy_next    = energy_reg;
        magy_next      = magy_reg;
        negx_next      = negx_reg;
        negy_next      = negy_reg;
        unit_next      = unit_reg;
        tube_next      = tube_reg;
        done_next      = done_reg;
        class_next     = class_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        qx_next        = qx_reg;
        cnt_next       = cnt_reg;
        mvalid_next    = mvalid_reg && !m_axis_tready;
        mdata_next     = mdata_reg;
        muser_next     = muser_reg;
        mlast_next     = mlast_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    hit_next    = in_hit;
                    ovf_next    = in_ovf;
                    lack_next   = in_lack;
                    energy_next = in_hit ? in_energy : '0;
                    negx_next   = sab < scd;
                    negy_next   = sad < sbc;
                    rem_next    = ENERGY_BITS'((sab < scd) ? scd - sab : sab - scd);
                    magy_next   = (sad < sbc) ? sbc - sad : sad - sbc;
                    quot_next   = '0;
                    cnt_next    = '0;
                    unit_next   = s_axis_tuser[UNIT_BITS-1:0];
                    tube_next   = s_axis_tuser[UNIT_BITS +: TUBE_BITS];
                    done_next   = s_axis_tlast;
                    class_next  = '0;
                    if (s_axis_tlast)
                    begin
                        class_next     = (evt_ovf || evt_lack) ? CLASS_ERROR
                                                               : CLASS_BITS'(tally_inc);
                        tally_next     = '0;
                        ovf_seen_next  = 1'b0;
                        lack_seen_next = 1'b0;
                    end
                    else
                    begin
                        tally_next     = tally_inc;
                        ovf_seen_next  = evt_ovf;
                        lack_seen_next = evt_lack;
                    end
                    state_next = in_hit ? ST_DIVX : ST_WRITE;
                end
            end
            ST_DIVX, ST_DIVY:
            begin
                rem_next  = div_ge ? rem_sub[ENERGY_BITS-1:0] : rem_sh[ENERGY_BITS-1:0];
                quot_next = {quot_reg[Q_BITS-2:0], div_ge};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(Q_BITS - 1))
                begin
                    cnt_next = '0;
                    if (state_reg == ST_DIVX)
                    begin
                        qx_next    = {quot_reg[Q_BITS-2:0], div_ge};
                        quot_next  = '0;
                        rem_next   = ENERGY_BITS'(magy_reg);
                        state_next = ST_DIVY;
                    end
                    else
                    begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_WRITE:
            begin
                if (out_load)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = '0;
                    mdata_next[OFS_HIT]                      = hit_reg;
                    mdata_next[OFS_ENERGY +: ENERGY_BITS]    = energy_reg;
                    mdata_next[OFS_POSX +: POS_BITS]         = posx;
                    mdata_next[OFS_POSY +: POS_BITS]         = posy;
                    mdata_next[OFS_OVF]                      = ovf_reg;
                    mdata_next[OFS_LACK]                     = lack_reg;
                    mdata_next[OFS_CLASS +: CLASS_BITS]      = class_reg;
                    muser_next  = {tube_reg, unit_reg};
                    mlast_next  = done_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            thr_reg       <= RESET_THRESHOLD;
            ovl_reg       <= RESET_OVERFLOW;
            tally_reg     <= '0;
            ovf_seen_reg  <= 1'b0;
            lack_seen_reg <= 1'b0;
            mvalid_reg    <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            tally_reg     <= tally_next;
            ovf_seen_reg  <= ovf_seen_next;
            lack_seen_reg <= lack_seen_next;
            mvalid_reg    <= mvalid_next;
            cnt_reg       <= cnt_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_HIT_THRESHOLD:  thr_reg <= cfg_wdata;
                    REG_OVERFLOW_LIMIT: ovl_reg <= cfg_wdata;
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg    <= hit_next;
        ovf_reg    <= ovf_next;
        lack_reg   <= lack_next;
        energy_reg <= energy_next;
        magy_reg   <= magy_next;
        negx_reg   <= negx_next;
        negy_reg   <= negy_next;
        unit_reg   <= unit_next;
        tube_reg   <= tube_next;
        done_reg   <= done_next;
        class_reg  <= class_next;
        rem_reg    <= rem_next;
        quot_reg   <= quot_next;
        qx_reg     <= qx_next;
        mdata_reg  <= mdata_next;
        muser_reg  <= muser_next;
        mlast_reg  <= mlast_next;
    end

endmodule
`default_nettype wire

### src/qach_checker.sv
// Port-level assertions for the hit classifier and their bind.
`default_nettype none
module qach_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_axis_tvalid,
    input wire logic                             s_axis_tready,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [qach_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                             m_axis_tlast
);
    import qach_pkg::*;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transfer");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[OFS_HIT]
            |-> m_axis_tdata[OFS_OVF-1:OFS_ENERGY] == '0)
        else $error("non-hit result carries energy or position");

    a_class_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast
            |-> m_axis_tdata[OFS_CLASS +: CLASS_BITS] == '0)
        else $error("class set outside event end");

    a_hit_lack_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[OFS_HIT] && m_axis_tdata[OFS_LACK]))
        else $error("hit and data lack both set");

endmodule

bind quad_anode_centroid_hit_classifier_top qach_checker u_qach_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

### tb/quad_anode_centroid_hit_classifier_top_tb.sv
// Testbench for quad_anode_centroid_hit_classifier_top: self-checking stream test with own predictor.
`timescale 1ns / 1ps
module quad_anode_centroid_hit_classifier_top_tb;
    import qach_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int MAX_SAMPLE     = (1 << ADC_BITS) - 1;
    localparam int MAX_POS        = (1 << Q_BITS) - 1;
    localparam int MAX_ENERGY     = (1 << ENERGY_BITS) - 1;
    localparam int TALLY_MAX      = (1 << TALLY_BITS) - 1;

    localparam int KIND_HIT  = 0;
    localparam int KIND_LOW  = 1;
    localparam int KIND_OVER = 2;
    localparam int KIND_ANY  = 3;
    localparam int KIND_EDGE = 4;

    typedef struct packed {
        logic [ADC_BITS-1:0]  a;
        logic [ADC_BITS-1:0]  b;
        logic [ADC_BITS-1:0]  c;
        logic [ADC_BITS-1:0]  d;
        logic [UNIT_BITS-1:0] unit;
        logic [TUBE_BITS-1:0] tube;
        logic                 last;
    } tube_sample_t;

    typedef struct {
        logic                       hit;
        logic [ENERGY_BITS-1:0]     energy;
        logic signed [POS_BITS-1:0] pos_x;
        logic signed [POS_BITS-1:0] pos_y;
        logic                       ovf;
        logic                       lack;
        logic [UNIT_BITS-1:0]       unit;
        logic [TUBE_BITS-1:0]       tube;
        logic                       done;
        logic [CLASS_BITS-1:0]      cls;
    } tube_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [0:0]             cfg_addr = REG_HIT_THRESHOLD;
    logic [CFG_BITS-1:0]    cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   m_axis_tlast;

    quad_anode_centroid_hit_classifier_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    tube_sample_t pending_tubes[$];
    tube_result_t expected_results[$];

    int  src_idle_pct = 0;
    int  snk_idle_pct = 0;
    bit  hold_kick = 1'b0;
    int  mismatches = 0;
    int  idle_cycles = 0;

    // predictor state and register shadows
    int  thr_shadow = RESET_THRESHOLD;
    int  ovf_shadow = RESET_OVERFLOW;
    int  hit_tally = 0;
    bit  event_ovf_seen = 1'b0;
    bit  event_lack_seen = 1'b0;

    function automatic logic signed [POS_BITS-1:0] q15_centroid(input longint num,
                                                                input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (den == 0) ? 0 : (mag << Q_BITS) / den;
        if (q > MAX_POS)
            q = MAX_POS;
        return POS_BITS'((num < 0) ? -q : q);
    endfunction

    function automatic tube_result_t predict_tube(input tube_sample_t it);
        tube_result_t r;
        int     s[4];
        longint energy;
        int     passed;
        s[0] = it.a;
        s[1] = it.b;
        s[2] = it.c;
        s[3] = it.d;
        energy = 0;
        passed = 0;
        r.ovf = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if (s[i] > ovf_shadow)
                r.ovf = 1'b1;
            else if (s[i] > thr_shadow)
            begin
                energy += s[i];
                passed++;
            end
        end
        r.hit = (passed == 4);
        r.lack = (passed > 0) && !r.hit;
        r.energy = '0;
        r.pos_x = '0;
        r.pos_y = '0;
        if (r.hit)
        begin
            r.energy = ENERGY_BITS'((energy > MAX_ENERGY) ? MAX_ENERGY : energy);
            r.pos_x = q15_centroid(longint'(s[0] + s[1]) - longint'(s[2] + s[3]), energy);
            r.pos_y = q15_centroid(longint'(s[0] + s[3]) - longint'(s[1] + s[2]), energy);
            if (hit_tally < TALLY_MAX)
                hit_tally++;
        end
        r.unit = it.unit;
        r.tube = it.tube;
        if (r.ovf)
            event_ovf_seen = 1'b1;
        if (r.lack)
            event_lack_seen = 1'b1;
        r.done = it.last;
        r.cls = '0;
        if (it.last)
        begin
            r.cls = (event_ovf_seen || event_lack_seen) ? CLASS_ERROR : CLASS_BITS'(hit_tally);
            hit_tally = 0;
            event_ovf_seen = 1'b0;
            event_lack_seen = 1'b0;
        end
        return r;
    endfunction

    task automatic note_mismatch(input string what, input int exp_val, input int act_val);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s expected %0d, got %0d", $time, what, exp_val, act_val);
    endtask

    // source side
    always @(posedge clk or negedge rst_n)
    begin : source_drive
        tube_sample_t nxt;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (pending_tubes.size() != 0 && $urandom_range(99, 0) >= src_idle_pct)
            begin
                nxt = pending_tubes.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= IN_TDATA_W'({nxt.d, nxt.c, nxt.b, nxt.a});
                s_axis_tuser  <= {nxt.tube, nxt.unit};
                s_axis_tlast  <= nxt.last;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // predict on every accepted input transfer
    always @(posedge clk)
    begin : source_capture
        tube_sample_t it;
        tube_result_t r;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            it.a    = s_axis_tdata[0*ADC_BITS +: ADC_BITS];
            it.b    = s_axis_tdata[1*ADC_BITS +: ADC_BITS];
            it.c    = s_axis_tdata[2*ADC_BITS +: ADC_BITS];
            it.d    = s_axis_tdata[3*ADC_BITS +: ADC_BITS];
            it.unit = s_axis_tuser[UNIT_BITS-1:0];
            it.tube = s_axis_tuser[UNIT_BITS +: TUBE_BITS];
            it.last = s_axis_tlast;
            r = predict_tube(it);
            expected_results = {expected_results, r};
        end
    end

    // sink side, with long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin : sink_drive
        int hold_left;
        bit kick_seen;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left = 0;
            kick_seen = 1'b0;
        end
        else
        begin
            if (hold_kick != kick_seen)
            begin
                kick_seen = hold_kick;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99, 0) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        tube_result_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result transfer with nothing expected", $time);
            end
            else
            begin
                e = expected_results.pop_front();
                if (m_axis_tdata[OFS_HIT] !== e.hit)
                    note_mismatch("hit_valid", e.hit, m_axis_tdata[OFS_HIT]);
                if (m_axis_tdata[OFS_ENERGY +: ENERGY_BITS] !== e.energy)
                    note_mismatch("energy_sum", e.energy, m_axis_tdata[OFS_ENERGY +: ENERGY_BITS]);
                if (m_axis_tdata[OFS_POSX +: POS_BITS] !== e.pos_x)
                    note_mismatch("pos_x", int'(e.pos_x),
                                  int'($signed(m_axis_tdata[OFS_POSX +: POS_BITS])));
                if (m_axis_tdata[OFS_POSY +: POS_BITS] !== e.pos_y)
                    note_mismatch("pos_y", int'(e.pos_y),
                                  int'($signed(m_axis_tdata[OFS_POSY +: POS_BITS])));
                if (m_axis_tdata[OFS_OVF] !== e.ovf)
                    note_mismatch("tube_overflow", e.ovf, m_axis_tdata[OFS_OVF]);
                if (m_axis_tdata[OFS_LACK] !== e.lack)
                    note_mismatch("tube_data_lack", e.lack, m_axis_tdata[OFS_LACK]);
                if (m_axis_tdata[OFS_CLASS +: CLASS_BITS] !== e.cls)
                    note_mismatch("event_class", e.cls, m_axis_tdata[OFS_CLASS +: CLASS_BITS]);
                if (m_axis_tuser[UNIT_BITS-1:0] !== e.unit)
                    note_mismatch("unit_echo", e.unit, m_axis_tuser[UNIT_BITS-1:0]);
                if (m_axis_tuser[UNIT_BITS +: TUBE_BITS] !== e.tube)
                    note_mismatch("tube_echo", e.tube, m_axis_tuser[UNIT_BITS +: TUBE_BITS]);
                if (m_axis_tlast !== e.done)
                    note_mismatch("event_done", e.done, m_axis_tlast);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("quad_anode_centroid_hit_classifier_top_tb NOT OK");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic add_tube(input int a, input int b, input int c, input int d,
                            input int unit, input int tube, input bit last);
        tube_sample_t it;
        it.a = ADC_BITS'(a);
        it.b = ADC_BITS'(b);
        it.c = ADC_BITS'(c);
        it.d = ADC_BITS'(d);
        it.unit = UNIT_BITS'(unit);
        it.tube = TUBE_BITS'(tube);
        it.last = last;
        pending_tubes = {pending_tubes, it};
    endtask

    function automatic int draw_sample(input int kind);
        int lo;
        int hi;
        lo = 0;
        hi = MAX_SAMPLE;
        case (kind)
            KIND_HIT:  begin lo = thr_shadow + 1; hi = ovf_shadow; end
            KIND_LOW:  hi = thr_shadow;
            KIND_OVER: lo = ovf_shadow + 1;
            KIND_EDGE: return $urandom_range(1, 0) ? MAX_SAMPLE : 0;
            default:   ;
        endcase
        if (lo > hi)
            return $urandom_range(MAX_SAMPLE, 0);
        return $urandom_range(hi, lo);
    endfunction

    // events of one to six tubes, mostly clean hits; some broken or noisy
    task automatic add_random_events(input int n_items);
        int count;
        int n_tubes;
        int unit;
        int mode;
        int odd;
        int kind;
        int s[4];
        bit last;
        count = 0;
        while (count < n_items)
        begin
            n_tubes = $urandom_range(TUBES_PER_UNIT, 1);
            unit = $urandom_range((1 << UNIT_BITS) - 1, 0);
            for (int t = 0; t < n_tubes; t++)
            begin
                mode = $urandom_range(99, 0);
                odd = $urandom_range(3, 0);
                for (int i = 0; i < 4; i++)
                begin
                    if (mode < 60)
                        kind = KIND_HIT;
                    else if (mode < 75)
                        kind = (i == odd) ? KIND_LOW : KIND_HIT;
                    else if (mode < 85)
                        kind = (i == odd) ? KIND_OVER : KIND_HIT;
                    else if (mode < 95)
                        kind = KIND_ANY;
                    else
                        kind = KIND_EDGE;
                    s[i] = draw_sample(kind);
                end
                last = (t == n_tubes - 1);
                if ($urandom_range(19, 0) == 0)
                    last = ~last;
                add_tube(s[0], s[1], s[2], s[3], unit,
                         ($urandom_range(9, 0) == 0) ? $urandom_range((1 << TUBE_BITS) - 1, 0) : t,
                         last);
                count++;
            end
        end
    endtask

    task automatic write_reg(input logic [0:0] idx, input int val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_BITS'(val);
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_HIT_THRESHOLD)
            thr_shadow = val;
        else
            ovf_shadow = val;
    endtask

    task automatic wait_drained();
        while (pending_tubes.size() != 0 || expected_results.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int thr, input int ovf, input int n_items,
                             input int src_pct, input int snk_pct, input bit kick);
        write_reg(REG_HIT_THRESHOLD, thr);
        write_reg(REG_OVERFLOW_LIMIT, ovf);
        @(negedge clk);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        if (kick)
            hold_kick = ~hold_kick;
        add_random_events(n_items);
        wait_drained();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        src_idle_pct = 28;
        snk_idle_pct = 71;

        // reset thresholds: one hit
        add_tube(34, 34, 34, 34, 0, 0, 1'b0);
        add_tube(0, 0, 0, 0, 15, 7, 1'b0);
        add_tube(33, 33, 33, 33, 5, 6, 1'b1);
        // two hits, x at both extremes
        add_tube(4000, 4000, 34, 34, 1, 0, 1'b0);
        add_tube(34, 34, 4000, 4000, 1, 1, 1'b1);
        // tally saturates
        add_tube(4000, 34, 34, 4000, 2, 0, 1'b0);
        add_tube(34, 4000, 4000, 34, 2, 1, 1'b0);
        add_tube(1000, 2000, 3000, 4000, 2, 2, 1'b0);
        add_tube(4000, 4000, 4000, 4000, 2, 3, 1'b1);
        // overflow beats hit count
        add_tube(4095, 4095, 4095, 4095, 3, 4, 1'b0);
        add_tube(500, 600, 700, 800, 3, 5, 1'b1);
        // data lack
        add_tube(34, 0, 0, 0, 4, 0, 1'b1);
        add_tube(4001, 100, 100, 100, 8, 2, 1'b1);
        // empty event
        add_tube(0, 0, 0, 0, 9, 3, 1'b1);
        wait_drained();

        run_phase(RESET_THRESHOLD, RESET_OVERFLOW, 120, 28, 71, 1'b0);
        run_phase(0, MAX_SAMPLE, 110, 71, 28, 1'b0);
        run_phase(MAX_SAMPLE, 0, 30, 71, 28, 1'b0);
        run_phase(MAX_SAMPLE, MAX_SAMPLE, 30, 71, 28, 1'b0);
        run_phase(0, 0, 30, 0, 0, 1'b0);
        run_phase($urandom_range(200, 0), $urandom_range(MAX_SAMPLE, 3500), 110, 0, 0, 1'b1);
        run_phase(200, 3000, 90, 0, 0, 1'b0);

        if (expected_results.size() != 0)
            $display("%0d results never arrived", expected_results.size());
        if (mismatches == 0 && expected_results.size() == 0)
            $display("quad_anode_centroid_hit_classifier_top_tb OK");
        else
            $display("quad_anode_centroid_hit_classifier_top_tb NOT OK");
        $finish;
    end

endmodule
